// ===== hdl/afu_pkg.sv =====
package afu_pkg;

    localparam int ROW_MAX_DEF     = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [3:0] MODE_LINEAR  = 4'd0;
    localparam logic [3:0] MODE_RELU    = 4'd1;
    localparam logic [3:0] MODE_LEAKY   = 4'd2;
    localparam logic [3:0] MODE_ELU     = 4'd3;
    localparam logic [3:0] MODE_SIGMOID = 4'd4;
    localparam logic [3:0] MODE_TANH    = 4'd5;
    localparam logic [3:0] MODE_SWISH   = 4'd6;
    localparam logic [3:0] MODE_GELU    = 4'd7;
    localparam logic [3:0] MODE_SOFTMAX = 4'd8;

    localparam logic REG_MODE       = 1'b0;
    localparam logic REG_ROW_LENGTH = 1'b1;

    localparam int Q16_ONE        = 65536;
    localparam int LEAK_Q16       = 655;
    localparam int GELU_CUBIC_Q16 = 2930;
    localparam int GELU_SCALE_Q16 = 52290;
    localparam int GELU_CLAMP     = 2048;
    localparam int EXP_LIMIT      = 3072;

    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 24;
    localparam int TOTAL_W   = 24;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_STORE, OP_ARG_SIG, OP_ARG_TANH, OP_ARG_SMX,
        OP_DIV_SIG, OP_DIV_TANH, OP_DIV_SMX, OP_SIG_FIN, OP_TANH_FIN,
        OP_MUL_LEAK, OP_MUL_SW, OP_MUL_WW, OP_V2, OP_MUL_AW, OP_V3,
        OP_MUL_C, OP_INNER, OP_MUL_S, OP_U, OP_MUL_G, OP_ACC, OP_RES,
        OP_NEXT, OP_ROW_CLR
    } t_op;

    typedef enum logic [2:0] {
        RS_PASS, RS_RELU, RS_LEAK, RS_ELU, RS_Q8, RS_SWISH, RS_GELU, RS_SMX
    } t_rsel;

    typedef struct packed {
        t_op   op;
        t_rsel rsel;
        logic  last;
        logic  exp_go;
        logic  div_go;
    } t_cmd;

    typedef struct packed {
        logic row_full;
        logic j_last;
        logic exp_done;
        logic div_done;
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE, S_LEAK, S_SIG_ARG, S_SE_WAIT, S_SIG_DIV, S_SD_WAIT, S_SIG_FIN,
        S_SWISH, S_TANH_ARG, S_TE_WAIT, S_TANH_DIV, S_TD_WAIT, S_TANH_FIN,
        S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7, S_G8, S_G_FIN, S_RES, S_OUT,
        S_P1_RD, S_P1_ARG, S_P1_WAIT, S_P1_ACC,
        S_P2_RD, S_P2_ARG, S_P2_WAIT, S_P2_DIV, S_P2_DWAIT, S_P2_RES, S_P2_OUT
    } t_state;

    // exp(-n), Q1.16
    function automatic logic [16:0] exp_whole(input logic [3:0] n);
        case (n)
            4'd0:    return 17'd65536;
            4'd1:    return 17'd24109;
            4'd2:    return 17'd8869;
            4'd3:    return 17'd3263;
            4'd4:    return 17'd1200;
            4'd5:    return 17'd442;
            4'd6:    return 17'd162;
            4'd7:    return 17'd60;
            4'd8:    return 17'd22;
            4'd9:    return 17'd8;
            4'd10:   return 17'd3;
            4'd11:   return 17'd1;
            default: return 17'd0;
        endcase
    endfunction

    // exp(-h/16), Q1.16
    function automatic logic [16:0] exp_sixteenth(input logic [3:0] h);
        case (h)
            4'd0:    return 17'd65536;
            4'd1:    return 17'd61565;
            4'd2:    return 17'd57835;
            4'd3:    return 17'd54331;
            4'd4:    return 17'd51039;
            4'd5:    return 17'd47947;
            4'd6:    return 17'd45042;
            4'd7:    return 17'd42313;
            4'd8:    return 17'd39750;
            4'd9:    return 17'd37341;
            4'd10:   return 17'd35079;
            4'd11:   return 17'd32954;
            4'd12:   return 17'd30957;
            4'd13:   return 17'd29081;
            4'd14:   return 17'd27319;
            default: return 17'd25664;
        endcase
    endfunction

    // exp(-l/256), Q1.16
    function automatic logic [16:0] exp_fine(input logic [3:0] l);
        case (l)
            4'd0:    return 17'd65536;
            4'd1:    return 17'd65280;
            4'd2:    return 17'd65026;
            4'd3:    return 17'd64772;
            4'd4:    return 17'd64520;
            4'd5:    return 17'd64268;
            4'd6:    return 17'd64018;
            4'd7:    return 17'd63768;
            4'd8:    return 17'd63520;
            4'd9:    return 17'd63272;
            4'd10:   return 17'd63025;
            4'd11:   return 17'd62781;
            4'd12:   return 17'd62535;
            4'd13:   return 17'd62291;
            4'd14:   return 17'd62048;
            default: return 17'd61806;
        endcase
    endfunction

endpackage

// ===== hdl/activation_function_unit.sv =====
// Activation unit on signed Q8.8 samples. The mode register picks linear, relu,
// leaky relu, elu, sigmoid, tanh, swish, gelu (tanh form) or softmax; unused mode
// codes act as linear. Elementwise modes give one result per sample with
// last_of_run high. Softmax buffers row_length samples (0 acts as 1, values
// above ROW_MAX act as ROW_MAX), gives no result until the row is complete, and
// then emits the whole row of probabilities with last_of_run on the final one.
// The block works on one transaction at a time. Sigmoid, tanh, swish and gelu
// run the bit-serial divider and the exp sequence on the shared multiplier;
// elu runs the exp sequence only. A softmax sample that does not close its row
// is only stored. Closing a row runs an exp-sum pass over its samples, then a
// normalize pass (exp plus divide) for each result, and each result waits to
// be taken. Registers: mode at byte address 0, row_length at 4.
module activation_function_unit import afu_pkg::*; #(
    parameter int ROW_MAX     = ROW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // sample channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_result,
    output logic                          o_last_of_run
);

    logic [3:0] r_mode;
    logic [6:0] r_row_length;
    logic       cfg_wr;
    t_cmd       cmd;
    t_status    status;

    // Write on the access phase; the port never stalls.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_LINEAR;
            r_row_length <= 7'd64;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MODE:       r_mode       <= pwdata[3:0];
                REG_ROW_LENGTH: r_row_length <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_ROW_LENGTH) ? 32'(r_row_length) : 32'(r_mode);

    // Sequence each transaction through the datapath.
    afu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Hold the row buffer, the exp and divide units and the result register.
    afu_dp #(.ROW_MAX(ROW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_sample      (i_sample),
        .i_row_length  (r_row_length),
        .o_result      (o_result),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== hdl/afu_ram.sv =====
module afu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/afu_div.sv =====
module afu_div import afu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quo
);

    localparam int CW = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic [CW-1:0]        r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W+1:0] diff;
    logic                 take;

    // restoring division, one quotient bit per cycle
    assign shifted = {r_rem, r_quo[DIV_NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};
    assign take    = ~diff[DIV_DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(DIV_NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= take ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], take};
        end
    end

    assign o_done = r_busy && (r_cnt == CW'(DIV_NUM_W - 1));
    assign o_quo  = r_quo;

endmodule

// ===== hdl/afu_dp.sv =====
module afu_dp import afu_pkg::*; #(
    parameter int ROW_MAX     = ROW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [6:0]                    i_row_length,
    output logic signed [SAMPLE_BITS-1:0] o_result,
    output logic                          o_last_of_run
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = ((SB > 18) ? SB : 18) + 1;
    localparam int BW = 19;
    localparam int PW = AW + BW;
    localparam int DW = ((SB + 1) > 16) ? SB + 1 : 16;
    localparam int FW = $clog2(ROW_MAX + 1);
    localparam int IW = $clog2(ROW_MAX);

    localparam logic signed [AW-1:0] CLAMP_P = AW'(GELU_CLAMP);
    localparam logic signed [AW-1:0] CLAMP_N = -CLAMP_P;
    localparam logic signed [PW-1:0] SAT_HI  = PW'((longint'(1) <<< (SB - 1)) - 1);
    localparam logic signed [PW-1:0] SAT_LO  = -SAT_HI - PW'(1);
    localparam logic signed [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};

    logic signed [AW-1:0] r_v, r_y, r_a;
    logic [DW-1:0]        r_d;
    logic signed [PW-1:0] r_prod;
    logic [16:0]          r_e;
    logic                 r_ez;
    logic [2:0]           r_xph;
    logic signed [17:0]   r_t;
    logic signed [SB-1:0] r_max;
    logic [FW-1:0]        r_fill;
    logic [IW-1:0]        r_j;
    logic [TOTAL_W-1:0]   r_total;
    logic signed [SB-1:0] r_out;
    logic                 r_last;

    logic signed [AW-1:0] w, mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p, res_val;
    logic [AW-1:0]        abs_y;
    logic [16:0]          exp_rnd;
    logic [17:0]          den_q;
    logic [DIV_NUM_W-1:0] div_num, div_q;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [SB-1:0]        ram_rdata;
    logic signed [SB:0]   smx_diff;
    logic [7:0]           len_eff;
    logic                 row_full, j_last;

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] x, input int s);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = x[PW-1] ? PW'(-x) : PW'(x);
        q   = (mag + (PW'(1) << (s - 1))) >> s;
        return x[PW-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [SB-1:0] sat(input logic signed [PW-1:0] x);
        if (x > SAT_HI) begin
            return SB'(SAT_HI);
        end else if (x < SAT_LO) begin
            return SB'(SAT_LO);
        end
        return SB'(x);
    endfunction

    assign w       = (r_v > CLAMP_P) ? CLAMP_P : ((r_v < CLAMP_N) ? CLAMP_N : r_v);
    assign abs_y   = r_y[AW-1] ? AW'(-r_y) : AW'(r_y);
    assign exp_rnd = 17'((r_prod + PW'(32768)) >>> 16);
    assign den_q   = 18'(Q16_ONE) + 18'(r_e);
    assign smx_diff = {r_max[SB-1], r_max} - {ram_rdata[SB-1], ram_rdata};

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_xph == 3'd1) begin
            mul_a = AW'(exp_whole(r_d[11:8]));
            mul_b = BW'(exp_sixteenth(r_d[7:4]));
        end else if (r_xph == 3'd3) begin
            mul_a = AW'(r_e);
            mul_b = BW'(exp_fine(r_d[3:0]));
        end else begin
            case (i_cmd.op)
                OP_MUL_LEAK: begin mul_a = r_v; mul_b = BW'(LEAK_Q16); end
                OP_MUL_SW:   begin mul_a = r_v; mul_b = BW'(r_t); end
                OP_MUL_WW:   begin mul_a = w;   mul_b = BW'(w); end
                OP_MUL_AW:   begin mul_a = r_a; mul_b = BW'(w); end
                OP_MUL_C:    begin mul_a = r_a; mul_b = BW'(GELU_CUBIC_Q16); end
                OP_MUL_S:    begin mul_a = r_a; mul_b = BW'(GELU_SCALE_Q16); end
                OP_MUL_G:    begin mul_a = r_v; mul_b = BW'(Q16_ONE) + BW'(r_t); end
                default:     begin mul_a = '0;  mul_b = '0; end
            endcase
        end
    end
    assign mul_p = mul_a * mul_b;

    // divider operands
    always_comb begin
        case (i_cmd.op)
            OP_DIV_SIG: begin
                div_num = (DIV_NUM_W'(1) << 32) + DIV_NUM_W'(den_q >> 1);
                div_den = DIV_DEN_W'(den_q);
            end
            OP_DIV_TANH: begin
                div_num = (DIV_NUM_W'(17'(Q16_ONE) - r_e) << 16) + DIV_NUM_W'(den_q >> 1);
                div_den = DIV_DEN_W'(den_q);
            end
            default: begin
                div_num = (DIV_NUM_W'(r_e) << 8) + DIV_NUM_W'(r_total >> 1);
                div_den = r_total;
            end
        endcase
    end

    afu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    afu_ram #(.WIDTH(SB), .DEPTH(ROW_MAX)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_STORE),
        .i_waddr (r_fill[IW-1:0]),
        .i_wdata (i_sample),
        .i_raddr (r_j),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (i_row_length == 7'd0) begin
            len_eff = 8'd1;
        end else if (8'(i_row_length) > 8'(ROW_MAX)) begin
            len_eff = 8'(ROW_MAX);
        end else begin
            len_eff = 8'(i_row_length);
        end
    end
    assign row_full = (8'(r_fill) + 8'd1) >= len_eff;
    assign j_last   = (8'(r_j) + 8'd1) == 8'(r_fill);

    always_comb begin
        case (i_cmd.rsel)
            RS_PASS:  res_val = PW'(r_v);
            RS_RELU:  res_val = (r_v > 0) ? PW'(r_v) : '0;
            RS_LEAK:  res_val = (r_v > 0) ? PW'(r_v) : rnd(r_prod, 16);
            RS_ELU:   res_val = (r_v > 0) ? PW'(r_v)
                                          : rnd($signed(PW'(r_e)) - PW'(Q16_ONE), 8);
            RS_Q8:    res_val = rnd(PW'(r_t), 8);
            RS_SWISH: res_val = rnd(r_prod, 16);
            RS_GELU:  res_val = rnd(r_prod, 17);
            default:  res_val = (r_total == '0) ? '0 : $signed(PW'(div_q[16:0]));
        endcase
    end

    // exp sequencer and row bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xph   <= '0;
            r_fill  <= '0;
            r_max   <= MOST_NEG;
            r_total <= '0;
            r_j     <= '0;
        end else begin
            if (i_cmd.exp_go) begin
                r_xph <= 3'd1;
            end else if (r_xph != 3'd0) begin
                r_xph <= (r_xph == 3'd4) ? 3'd0 : r_xph + 3'd1;
            end
            case (i_cmd.op)
                OP_STORE: begin
                    r_fill <= r_fill + FW'(1);
                    if (i_sample > r_max) begin
                        r_max <= i_sample;
                    end
                end
                OP_ACC: begin
                    r_total <= r_total + TOTAL_W'(r_e);
                    r_j     <= j_last ? '0 : r_j + IW'(1);
                end
                OP_NEXT: r_j <= r_j + IW'(1);
                OP_ROW_CLR: begin
                    r_fill  <= '0;
                    r_max   <= MOST_NEG;
                    r_total <= '0;
                    r_j     <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_xph)
            3'd1: begin
                r_ez   <= r_d >= DW'(EXP_LIMIT);
                r_prod <= mul_p;
            end
            3'd2: r_e    <= exp_rnd;
            3'd3: r_prod <= mul_p;
            3'd4: r_e    <= r_ez ? '0 : exp_rnd;
            default: ;
        endcase
        case (i_cmd.op)
            OP_LOAD: begin
                r_v <= AW'(i_sample);
                r_y <= AW'(i_sample);
            end
            OP_ARG_SIG:  r_d <= DW'(abs_y);
            OP_ARG_TANH: r_d <= DW'(abs_y << 1);
            OP_ARG_SMX:  r_d <= DW'(smx_diff);
            OP_SIG_FIN:  r_t <= r_y[AW-1] ? $signed(18'(Q16_ONE) - 18'(div_q[16:0]))
                                          : $signed(18'(div_q[16:0]));
            OP_TANH_FIN: r_t <= r_y[AW-1] ? -$signed(18'(div_q[16:0]))
                                          : $signed(18'(div_q[16:0]));
            OP_MUL_LEAK, OP_MUL_SW, OP_MUL_WW, OP_MUL_AW, OP_MUL_C, OP_MUL_S,
            OP_MUL_G:    r_prod <= mul_p;
            OP_V2, OP_V3: r_a <= AW'(rnd(r_prod, 8));
            OP_INNER:    r_a <= w + AW'(rnd(r_prod, 16));
            OP_U:        r_y <= AW'(rnd(r_prod, 16));
            OP_RES: begin
                r_out  <= sat(res_val);
                r_last <= i_cmd.last;
            end
            default: ;
        endcase
    end

    assign o_status.row_full = row_full;
    assign o_status.j_last   = j_last;
    assign o_status.exp_done = (r_xph == 3'd4);
    assign o_status.div_done = div_done;
    assign o_result      = r_out;
    assign o_last_of_run = r_last;

endmodule

// ===== hdl/afu_ctrl.sv =====
module afu_ctrl import afu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_mode,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode) inside
                        MODE_SOFTMAX:           n_state = i_status.row_full ? S_P1_RD : S_IDLE;
                        MODE_LEAKY:             n_state = S_LEAK;
                        MODE_ELU, MODE_SIGMOID,
                        MODE_SWISH:             n_state = S_SIG_ARG;
                        MODE_TANH:              n_state = S_TANH_ARG;
                        MODE_GELU:              n_state = S_G1;
                        default:                n_state = S_RES;
                    endcase
                end
            end
            S_LEAK:     n_state = S_RES;
            S_SIG_ARG:  n_state = S_SE_WAIT;
            S_SE_WAIT: begin
                if (i_status.exp_done) begin
                    n_state = (i_mode == MODE_ELU) ? S_RES : S_SIG_DIV;
                end
            end
            S_SIG_DIV:  n_state = S_SD_WAIT;
            S_SD_WAIT:  if (i_status.div_done) n_state = S_SIG_FIN;
            S_SIG_FIN:  n_state = (i_mode == MODE_SWISH) ? S_SWISH : S_RES;
            S_SWISH:    n_state = S_RES;
            S_TANH_ARG: n_state = S_TE_WAIT;
            S_TE_WAIT:  if (i_status.exp_done) n_state = S_TANH_DIV;
            S_TANH_DIV: n_state = S_TD_WAIT;
            S_TD_WAIT:  if (i_status.div_done) n_state = S_TANH_FIN;
            S_TANH_FIN: n_state = (i_mode == MODE_GELU) ? S_G_FIN : S_RES;
            S_G1:       n_state = S_G2;
            S_G2:       n_state = S_G3;
            S_G3:       n_state = S_G4;
            S_G4:       n_state = S_G5;
            S_G5:       n_state = S_G6;
            S_G6:       n_state = S_G7;
            S_G7:       n_state = S_G8;
            S_G8:       n_state = S_TANH_ARG;
            S_G_FIN:    n_state = S_RES;
            S_RES:      n_state = S_OUT;
            S_OUT:      if (i_out_ready) n_state = S_IDLE;
            S_P1_RD:    n_state = S_P1_ARG;
            S_P1_ARG:   n_state = S_P1_WAIT;
            S_P1_WAIT:  if (i_status.exp_done) n_state = S_P1_ACC;
            S_P1_ACC:   n_state = i_status.j_last ? S_P2_RD : S_P1_RD;
            S_P2_RD:    n_state = S_P2_ARG;
            S_P2_ARG:   n_state = S_P2_WAIT;
            S_P2_WAIT:  if (i_status.exp_done) n_state = S_P2_DIV;
            S_P2_DIV:   n_state = S_P2_DWAIT;
            S_P2_DWAIT: if (i_status.div_done) n_state = S_P2_RES;
            S_P2_RES:   n_state = S_P2_OUT;
            S_P2_OUT: begin
                if (i_out_ready) begin
                    n_state = i_status.j_last ? S_IDLE : S_P2_RD;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op     = OP_NONE;
        o_cmd.rsel   = RS_PASS;
        o_cmd.last   = 1'b1;
        o_cmd.exp_go = 1'b0;
        o_cmd.div_go = 1'b0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = (i_mode == MODE_SOFTMAX) ? OP_STORE : OP_LOAD;
                end
            end
            S_LEAK:     o_cmd.op = OP_MUL_LEAK;
            S_SIG_ARG:  begin o_cmd.op = OP_ARG_SIG;  o_cmd.exp_go = 1'b1; end
            S_SIG_DIV:  begin o_cmd.op = OP_DIV_SIG;  o_cmd.div_go = 1'b1; end
            S_SIG_FIN:  o_cmd.op = OP_SIG_FIN;
            S_SWISH:    o_cmd.op = OP_MUL_SW;
            S_TANH_ARG: begin o_cmd.op = OP_ARG_TANH; o_cmd.exp_go = 1'b1; end
            S_TANH_DIV: begin o_cmd.op = OP_DIV_TANH; o_cmd.div_go = 1'b1; end
            S_TANH_FIN: o_cmd.op = OP_TANH_FIN;
            S_G1:       o_cmd.op = OP_MUL_WW;
            S_G2:       o_cmd.op = OP_V2;
            S_G3:       o_cmd.op = OP_MUL_AW;
            S_G4:       o_cmd.op = OP_V3;
            S_G5:       o_cmd.op = OP_MUL_C;
            S_G6:       o_cmd.op = OP_INNER;
            S_G7:       o_cmd.op = OP_MUL_S;
            S_G8:       o_cmd.op = OP_U;
            S_G_FIN:    o_cmd.op = OP_MUL_G;
            S_RES: begin
                o_cmd.op = OP_RES;
                case (i_mode) inside
                    MODE_RELU:              o_cmd.rsel = RS_RELU;
                    MODE_LEAKY:             o_cmd.rsel = RS_LEAK;
                    MODE_ELU:               o_cmd.rsel = RS_ELU;
                    MODE_SIGMOID, MODE_TANH: o_cmd.rsel = RS_Q8;
                    MODE_SWISH:             o_cmd.rsel = RS_SWISH;
                    MODE_GELU:              o_cmd.rsel = RS_GELU;
                    default:                o_cmd.rsel = RS_PASS;
                endcase
            end
            S_OUT:      o_out_valid = 1'b1;
            S_P1_ARG:   begin o_cmd.op = OP_ARG_SMX; o_cmd.exp_go = 1'b1; end
            S_P1_ACC:   o_cmd.op = OP_ACC;
            S_P2_ARG:   begin o_cmd.op = OP_ARG_SMX; o_cmd.exp_go = 1'b1; end
            S_P2_DIV:   begin o_cmd.op = OP_DIV_SMX; o_cmd.div_go = 1'b1; end
            S_P2_RES: begin
                o_cmd.op   = OP_RES;
                o_cmd.rsel = RS_SMX;
                o_cmd.last = i_status.j_last;
            end
            S_P2_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.op = i_status.j_last ? OP_ROW_CLR : OP_NEXT;
                end
            end
            default: ;
        endcase
    end

endmodule
